// File: rtl/base64_stream_codec_macros.svh
// ----------------------------------------------------------------------------
// base64_stream_codec_macros
// Assertion macros used by the codec checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

// Same-cycle implication, reset gated.
`define B64SC_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");

// Next-cycle implication, reset gated.
`define B64SC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");

`endif

// File: rtl/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, codes and alphabet functions of the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

	localparam logic       MODE_ENCODE = 1'b0;
	localparam logic       MODE_DECODE = 1'b1;
	localparam logic [7:0] PAD_CHAR    = 8'h3D;
	localparam int         RES_SLOTS   = 4;

	typedef struct packed {
		logic [7:0] data_in;
		logic       last_in;
	} b64sc_in_t;

	typedef struct packed {
		logic [7:0] out_value;
		logic       has_value;
		logic       out_last;
	} b64sc_out_t;

	// results of one input item, slot 0 first
	typedef struct packed {
		b64sc_out_t [RES_SLOTS-1:0] item;
		logic [2:0]                 count;
	} b64sc_bundle_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} b64sc_dec_t;

	function automatic logic [7:0] enc_char(input logic [5:0] idx);
		logic [7:0] wide;
		wide = {2'b00, idx};
		if (idx < 6'd26) begin
			return 8'h41 + wide;
		end else if (idx < 6'd52) begin
			return 8'h61 + wide - 8'd26;
		end else if (idx < 6'd62) begin
			return 8'h30 + wide - 8'd52;
		end else if (idx == 6'd62) begin
			return 8'h2B;
		end
		return 8'h2F;
	endfunction

	function automatic b64sc_dec_t dec_char(input logic [7:0] c);
		b64sc_dec_t r;
		logic [7:0] t;
		r = '0;
		t = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'h41;
			r.ok = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			t = c - 8'h61 + 8'd26;
			r.ok = 1'b1;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30 + 8'd52;
			r.ok = 1'b1;
		end else if (c == 8'h2B) begin
			t = 8'd62;
			r.ok = 1'b1;
		end else if (c == 8'h2F) begin
			t = 8'd63;
			r.ok = 1'b1;
		end
		r.val = t[5:0];
		return r;
	endfunction

endpackage

// File: rtl/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder/decoder (standard alphabet) with a mode register.
// ----------------------------------------------------------------------------
// Write mode through cfg_wen/cfg_wdata while the block is idle: 0 encodes
// bytes to characters, 1 decodes characters to bytes; every write clears the
// codec state and aborts a message in progress. Items enter on src_* and
// results leave on dst_*, one transaction per cycle on each side when not
// stalled. An item is held in the input register until the result register
// is free, then all its results (up to four) load into a four-slot result
// register in one step, from which they are offered one at a time. The
// single result port sets the rate: an encoded byte sends one or two
// characters through it, up to four on the closing byte; a decoded character
// sends at most one byte, and characters that yield no byte pass without
// using the port unless they close a message, which gives an empty result.
// The next item loads in the same cycle the final queued result is taken, so
// encoded output runs without gaps while items keep coming under no stall.
// ----------------------------------------------------------------------------
module base64_stream_codec
	import b64sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic       cfg_wdata,
	input  logic       src_valid,
	output logic       src_stall,
	input  b64sc_in_t  src_data,
	output logic       dst_valid,
	input  logic       dst_stall,
	output b64sc_out_t dst_data
);

	b64sc_in_t     item_s1;
	logic          valid_s1_q;
	logic          free;
	logic          load;
	b64sc_bundle_t bundle;

	// advance the held item once the result slots can take its results
	assign load      = valid_s1_q && free;
	assign src_stall = valid_s1_q && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1_q <= 1'b1;
		end else if (load) begin
			valid_s1_q <= 1'b0;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_data;
		end
	end

	// build all results of the held item and update the bit state
	b64sc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.item      (item_s1),
		.fire      (load),
		.bundle    (bundle)
	);

	// drain the results one transaction at a time
	b64sc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.load      (load),
		.free      (free),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule

// File: rtl/b64sc_core.sv
// ----------------------------------------------------------------------------
// b64sc_core
// Mode register, bit accumulator state and the per-item result builder.
// ----------------------------------------------------------------------------
module b64sc_core
	import b64sc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic          cfg_wdata,
	input  b64sc_in_t     item,
	input  logic          fire,
	output b64sc_bundle_t bundle
);

	logic       mode_q;
	logic [5:0] acc_q;
	logic [2:0] cnt_q;
	logic [1:0] phase_q;
	logic       halt_q;

	logic [5:0] acc_n;
	logic [2:0] cnt_n;
	logic [1:0] phase_n;
	logic       halt_n;

	always_comb begin
		logic [11:0] w;
		logic [5:0]  c0;
		logic [5:0]  flush;
		logic        two;
		logic        has_rem;
		logic [2:0]  n;
		logic [1:0]  ph;
		b64sc_dec_t  d;
		logic [7:0]  byte_v;
		logic        has_byte;

		bundle   = '0;
		acc_n    = acc_q;
		cnt_n    = cnt_q;
		phase_n  = phase_q;
		halt_n   = halt_q;
		c0       = '0;
		flush    = '0;
		two      = 1'b0;
		has_rem  = 1'b0;
		n        = '0;
		ph       = phase_q;
		d        = dec_char(item.data_in);
		byte_v   = '0;
		has_byte = 1'b0;
		w        = {acc_q[3:0], item.data_in};

		if (mode_q == MODE_ENCODE) begin
			case (cnt_q)
				3'd2: begin
					c0      = w[9:4];
					flush   = {w[3:0], 2'b00};
					has_rem = 1'b1;
					acc_n   = {2'b00, w[3:0]};
					cnt_n   = 3'd4;
				end
				3'd4: begin
					c0    = w[11:6];
					two   = 1'b1;
					acc_n = '0;
					cnt_n = 3'd0;
				end
				default: begin
					c0      = w[7:2];
					flush   = {w[1:0], 4'b0000};
					has_rem = 1'b1;
					acc_n   = {4'b0000, w[1:0]};
					cnt_n   = 3'd2;
				end
			endcase
			bundle.item[0] = '{out_value: enc_char(c0), has_value: 1'b1, out_last: 1'b0};
			n  = 3'd1;
			ph = ph + 2'd1;
			if (two) begin
				bundle.item[1] = '{out_value: enc_char(w[5:0]), has_value: 1'b1,
					out_last: 1'b0};
				n  = 3'd2;
				ph = ph + 2'd1;
			end
			if (item.last_in) begin
				if (has_rem) begin
					bundle.item[n[1:0]] = '{out_value: enc_char(flush), has_value: 1'b1,
						out_last: 1'b0};
					n  = n + 3'd1;
					ph = ph + 2'd1;
				end
				for (int k = 0; k < RES_SLOTS; k++) begin
					if (ph != 2'd0 && n < 3'd4) begin
						bundle.item[n[1:0]] = '{out_value: PAD_CHAR, has_value: 1'b1,
							out_last: 1'b0};
						n  = n + 3'd1;
						ph = ph + 2'd1;
					end
				end
				bundle.item[n[1:0] - 2'd1].out_last = 1'b1;
			end
			phase_n = ph;
		end else begin
			w = {acc_q, d.val};
			if (!halt_q) begin
				if (!d.ok) begin
					halt_n = 1'b1;
				end else begin
					case (cnt_q)
						3'd2: begin
							byte_v   = w[7:0];
							has_byte = 1'b1;
							acc_n    = '0;
							cnt_n    = 3'd0;
						end
						3'd4: begin
							byte_v   = w[9:2];
							has_byte = 1'b1;
							acc_n    = {4'b0000, w[1:0]};
							cnt_n    = 3'd2;
						end
						3'd6: begin
							byte_v   = w[11:4];
							has_byte = 1'b1;
							acc_n    = {2'b00, w[3:0]};
							cnt_n    = 3'd4;
						end
						default: begin
							acc_n = d.val;
							cnt_n = 3'd6;
						end
					endcase
				end
			end
			if (has_byte) begin
				bundle.item[0] = '{out_value: byte_v, has_value: 1'b1,
					out_last: item.last_in};
				n = 3'd1;
			end else if (item.last_in) begin
				bundle.item[0] = '{out_value: 8'h00, has_value: 1'b0, out_last: 1'b1};
				n = 3'd1;
			end
		end

		bundle.count = n;

		// message end: drop all pending bits
		if (item.last_in) begin
			acc_n   = '0;
			cnt_n   = '0;
			phase_n = '0;
			halt_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENCODE;
			acc_q   <= '0;
			cnt_q   <= '0;
			phase_q <= '0;
			halt_q  <= 1'b0;
		end else if (cfg_wen) begin
			mode_q  <= cfg_wdata;
			acc_q   <= '0;
			cnt_q   <= '0;
			phase_q <= '0;
			halt_q  <= 1'b0;
		end else if (fire) begin
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			phase_q <= phase_n;
			halt_q  <= halt_n;
		end
	end

endmodule

// File: rtl/b64sc_outbuf.sv
// ----------------------------------------------------------------------------
// b64sc_outbuf
// Four-slot result register, drained one transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64sc_outbuf
	import b64sc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  b64sc_bundle_t bundle,
	input  logic          load,
	output logic          free,
	output logic          dst_valid,
	input  logic          dst_stall,
	output b64sc_out_t    dst_data
);

	b64sc_out_t [RES_SLOTS-1:0] item_s2;
	logic [2:0]                 left_q;
	logic [1:0]                 rd_q;
	logic                       pop;

	assign dst_valid = (left_q != 3'd0);
	assign dst_data  = item_s2[rd_q];
	assign pop       = dst_valid && !dst_stall;
	// empty now, or the last slot leaves this cycle
	assign free      = (left_q == 3'd0) || (left_q == 3'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			rd_q   <= '0;
		end else if (load) begin
			left_q <= bundle.count;
			rd_q   <= '0;
		end else if (pop) begin
			left_q <= left_q - 3'd1;
			rd_q   <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= bundle.item;
		end
	end

endmodule

// File: rtl/b64sc_checker.sv
// ----------------------------------------------------------------------------
// b64sc_checker
// Port-level checks of the Base64 stream codec, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_macros.svh"

module b64sc_checker
	import b64sc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       dst_valid,
	input logic       dst_stall,
	input b64sc_out_t dst_data
);

	// a stalled result holds
	`B64SC_ASSERT_NEXT(a_dst_hold, clk, arst_n, dst_valid && dst_stall, dst_valid && $stable(dst_data))

	// a result without a value only closes a message
	`B64SC_ASSERT_NOW(a_empty_is_last, clk, arst_n, dst_valid && !dst_data.has_value, dst_data.out_last)

	// the empty closing result carries a zero value
	`B64SC_ASSERT_NOW(a_empty_is_zero, clk, arst_n, dst_valid && !dst_data.has_value, dst_data.out_value == 8'h00)

endmodule

bind base64_stream_codec b64sc_checker u_b64sc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.dst_valid (dst_valid),
	.dst_stall (dst_stall),
	.dst_data  (dst_data)
);

// File: dv/tb_base64_stream_codec.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_codec
// Self-checking testbench for the streaming Base64 codec.
// A small class mirrors the codec state and queues the characters or bytes
// that each accepted transaction must produce. Results are matched in order
// against that queue. Directed messages cover padding, halting on invalid
// characters, empty closing results and aborts by a mode write. Random
// messages follow, with idle bursts on both sides and one long output
// hold-off that backs the codec up into its input.
// ----------------------------------------------------------------------------
module tb_base64_stream_codec;
	timeunit 1ns;
	timeprecision 1ps;
	import b64sc_pkg::*;

	// Software copy of the codec: tracks mode and pending bits, and queues the
	// results every accepted input transaction must produce.
	class b64_stream_mirror;
		string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		logic        mode;
		logic [11:0] acc;
		int          nbits;
		logic [1:0]  nchars;
		bit          halted;
		b64sc_out_t  awaited[$];
		int          mismatches;

		function new();
			mode = MODE_ENCODE;
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			acc = '0;
			nbits = 0;
			nchars = '0;
			halted = 1'b0;
		endfunction

		function void set_mode(input logic m);
			mode = m;
			clear();
		endfunction

		function int sextet_of(input logic [7:0] c);
			for (int i = 0; i < 64; i++) begin
				if (alphabet[i] == c) begin
					return i;
				end
			end
			return -1;
		endfunction

		function void push(input logic [7:0] v, input logic h, input logic l);
			b64sc_out_t r;
			r.out_value = v;
			r.has_value = h;
			r.out_last = l;
			awaited = {awaited, r};
		endfunction

		function void absorb_item(input b64sc_in_t it);
			logic [5:0]  idx;
			logic [11:0] shifted;
			int          v;
			bit          produced;
			produced = 1'b0;
			if (mode == MODE_ENCODE) begin
				acc = {acc[3:0], it.data_in};
				nbits += 8;
				while (nbits >= 6) begin
					idx = acc[nbits-1 -: 6];
					push(alphabet[idx], 1'b1, 1'b0);
					nbits -= 6;
					acc &= (12'h001 << nbits) - 12'h001;
					nchars++;
				end
				if (it.last_in) begin
					// flush leftover bits, zero-filled on the right, then pad
					if (nbits > 0) begin
						shifted = acc << (6 - nbits);
						push(alphabet[shifted[5:0]], 1'b1, 1'b0);
						nchars++;
					end
					while (nchars != 2'd0) begin
						push(PAD_CHAR, 1'b1, 1'b0);
						nchars++;
					end
					// mark the final character of the message
					awaited[awaited.size() - 1].out_last = 1'b1;
					clear();
				end
			end else begin
				if (!halted) begin
					v = sextet_of(it.data_in);
					if (v < 0) begin
						halted = 1'b1;
					end else begin
						acc = {acc[5:0], v[5:0]};
						nbits += 6;
						if (nbits >= 8) begin
							push(acc[nbits-1 -: 8], 1'b1, it.last_in);
							produced = 1'b1;
							nbits -= 8;
							acc &= (12'h001 << nbits) - 12'h001;
						end
					end
				end
				if (it.last_in) begin
					if (!produced) begin
						push(8'h00, 1'b0, 1'b1);
					end
					clear();
				end
			end
		endfunction

		function void match_output(input b64sc_out_t got);
			b64sc_out_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result with nothing pending: value %02h has %0b last %0b",
						$realtime, got.out_value, got.has_value, got.out_last);
				end
				return;
			end
			want = awaited.pop_front();
			if (got.out_value !== want.out_value || got.has_value !== want.has_value ||
					got.out_last !== want.out_last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch: expected value %02h has %0b last %0b, got %02h %0b %0b",
						$realtime, want.out_value, want.has_value, want.out_last,
						got.out_value, got.has_value, got.out_last);
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cfg_wen   = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	b64sc_in_t  src_data  = '0;
	logic       dst_valid;
	logic       dst_stall = 1'b0;
	b64sc_out_t dst_data;

	b64_stream_mirror mirror;
	bit src_gaps     = 1'b0;
	bit dst_gaps     = 1'b0;
	bit pressure_req = 1'b0;
	int items_sent   = 0;

	base64_stream_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offer one input transaction and hold it until the codec takes it. Call at
	// a rising edge; returns at the edge of acceptance with valid still high.
	task automatic send_item(input logic [7:0] data, input logic last);
		b64sc_in_t it;
		it.data_in = data;
		it.last_in = last;
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= it;
		do @(posedge clk); while (src_stall);
		mirror.absorb_item(it);
		items_sent++;
	endtask

	// Send a string as one message; close it with last unless told not to.
	task automatic send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], close && i == s.len() - 1);
		end
	endtask

	// Drop valid, wait for every pending result plus the pipeline depth, then
	// write the mode register. Any write clears the codec state.
	task automatic write_mode(input logic m);
		src_valid <= 1'b0;
		while (mirror.awaited.size() != 0) @(posedge clk);
		// characters that yield no byte may still sit in the input stage
		repeat (8) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_wen <= 1'b0;
		mirror.set_mode(m);
	endtask

	// Random message. Decode traffic is mostly alphabet characters, sometimes
	// with trailing pad, and occasionally an arbitrary byte that may halt it.
	task automatic send_random_message(input int len, input bit close);
		logic [7:0] d;
		for (int i = 0; i < len; i++) begin
			if (mirror.mode == MODE_ENCODE || $urandom_range(0, 9) == 0) begin
				d = 8'($urandom_range(0, 255));
			end else if (i >= len - 2 && $urandom_range(0, 4) == 0) begin
				d = PAD_CHAR;
			end else begin
				d = mirror.alphabet[$urandom_range(0, 63)];
			end
			send_item(d, close && i == len - 1);
		end
	endtask

	// Output side: check every accepted result, then pick the next stall
	// value. A pressure request holds the output for a long counted stretch.
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (dst_valid && !dst_stall) begin
				mirror.match_output(dst_data);
			end
			if (pressure_req) begin
				pressure_req = 1'b0;
				stall_left = 300;
			end else if (stall_left == 0 && dst_gaps && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 15);
			end
			if (stall_left > 0) begin
				dst_stall <= 1'b1;
				stall_left--;
			end else begin
				dst_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int  phase;
		bit  m;
		mirror = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rewrite the reset value: the write must still clear state.
		write_mode(MODE_ENCODE);
		// One, two and three byte messages: two pads, one pad, none.
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b1);
		send_text("Man", 1'b1);
		// Leave bits pending, then abort the message with a mode write.
		send_item(8'hA5, 1'b0);
		write_mode(MODE_ENCODE);
		send_item(8'h5A, 1'b1);

		write_mode(MODE_DECODE);
		send_text("TWFu", 1'b1);
		send_text("/+9z", 1'b1);
		// Pad halts decoding; the dangling bits are dropped and the closing
		// pad gives an empty marked result.
		send_text("QQ==", 1'b1);
		// Lone character: too few bits for a byte.
		send_text("A", 1'b1);
		// Invalid byte halts, a later last still closes the message.
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		// Abort a half-built decode; the next character must start fresh.
		send_text("Z", 1'b0);
		write_mode(MODE_DECODE);
		send_text("g", 1'b1);

		// Random phases, each with its own mode and idling mix. The final
		// phase runs with no idling on either side.
		phase = 0;
		while (items_sent < 260) begin
			src_gaps = $urandom_range(0, 1);
			dst_gaps = $urandom_range(0, 1);
			if (items_sent > 210) begin
				src_gaps = 1'b0;
				dst_gaps = 1'b0;
			end
			m = (phase == 1) ? MODE_ENCODE : 1'($urandom_range(0, 1));
			write_mode(m);
			if (phase == 1) begin
				// Hold the output and keep pushing bytes until input stalls.
				pressure_req = 1'b1;
				send_random_message(40, 1'b1);
			end
			repeat ($urandom_range(3, 8)) begin
				send_random_message($urandom_range(1, 12), 1'b1);
			end
			// Sometimes end the phase mid-message; the next write aborts it.
			if ($urandom_range(0, 2) == 0) begin
				send_random_message($urandom_range(1, 5), 1'b0);
			end
			phase++;
		end

		src_valid <= 1'b0;
		src_gaps = 1'b0;
		dst_gaps = 1'b0;
		while (mirror.awaited.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
